/* hdl/fmcw_chirp_freq_phase_defines.svh */
// assertion macros for the chirp generator
`ifndef FMCW_CHIRP_FREQ_PHASE_DEFINES_SVH
`define FMCW_CHIRP_FREQ_PHASE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define FCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcp check failed");

// next-cycle implication
`define FCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcp check failed");

`endif

/* hdl/fcp_pkg.sv */
package fcp_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int FREQ_WIDTH_DEF = 32;
  localparam int CFG_W          = 32;
  localparam int PER_W          = 32;
  localparam int DIV_W          = PER_W + 1;

  typedef enum logic [1:0] {
    MODE_TRI = 2'd0,
    MODE_SAW = 2'd1,
    MODE_OFF = 2'd2
  } chirp_mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_BASE   = 2'd1,
    REG_BW     = 2'd2,
    REG_PERIOD = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] bw;
    logic [CFG_W-1:0] period;
  } chirp_cfg_t;

endpackage

/* hdl/fcp_div_pipe.sv */
module fcp_div_pipe
  import fcp_pkg::*;
#(
  parameter int NUM_W  = 48,
  parameter int QUO_W  = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DIV_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  // one restoring step per stage, dividend msb first
  logic              vld_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [DIV_W-1:0]  rem_q  [NUM_W];
  logic [QUO_W-1:0]  quo_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_s;
    logic [NUM_W-1:0]  n_s;
    logic [DIV_W-1:0]  r_s;
    logic [QUO_W-1:0]  q_s;
    logic [SIDE_W-1:0] sd_s;
    logic [DIV_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_s  = vld_i;
      assign n_s  = num_i;
      assign r_s  = '0;
      assign q_s  = '0;
      assign sd_s = side_i;
    end else begin : g_next
      assign v_s  = vld_q[k-1];
      assign n_s  = num_q[k-1];
      assign r_s  = rem_q[k-1];
      assign q_s  = quo_q[k-1];
      assign sd_s = side_q[k-1];
    end

    assign trial = {r_s, n_s[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= n_s << 1;
        rem_q[k]  <= ge ? DIV_W'(trial - {1'b0, den_i}) : trial[DIV_W-1:0];
        quo_q[k]  <= {q_s[QUO_W-2:0], ge};
        side_q[k] <= sd_s;
      end
    end
  end

  assign vld_o  = vld_q[NUM_W-1];
  assign quo_o  = quo_q[NUM_W-1];
  assign rem_o  = rem_q[NUM_W-1];
  assign side_o = side_q[NUM_W-1];

endmodule

/* hdl/fcp_fold_mul.sv */
module fcp_fold_mul
  import fcp_pkg::*;
#(
  parameter int FREQ_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  chirp_cfg_t         cfg_i,
  input  logic [PER_W-1:0]   per_i,
  input  logic               vld_i,
  input  logic [DIV_W-1:0]   rem_i,
  input  logic               neg_i,
  output logic               vld_o,
  output logic [FREQ_W+63:0] off_num_o,
  output logic [FREQ_W+63:0] quad_num_o,
  output logic [FREQ_W-1:0]  bh_o
);

  localparam int HH_W  = 2 * PER_W;
  localparam int NUM_W = FREQ_W + HH_W;

  logic [FREQ_W-1:0] base_w, bw_w;
  logic [PER_W-1:0]  r_w, e_w, h_tri, h_w;
  logic [PER_W:0]    n1_w;
  logic              saw;

  logic [3:0]              vld_q;
  logic [PER_W-1:0]        a_h_q;
  logic [PER_W:0]          a_n1_q;
  logic [FREQ_W+PER_W:0]   b_prod_q, c_prod_q;
  logic [HH_W-1:0]         b_hh_q;
  logic [FREQ_W-1:0]       b_bh_q, c_bh_q, d_bh_q;
  logic [FREQ_W+PER_W-1:0] c_plo_q, c_phi_q;
  logic [NUM_W-1:0]        d_off_q, d_quad_q;

  assign base_w = FREQ_W'(cfg_i.base);
  assign bw_w   = FREQ_W'(cfg_i.bw);
  assign saw    = cfg_i.mode == MODE_SAW;

  // floored modulo fix-up for negative time, then triangle fold in triangle mode
  assign r_w   = rem_i[PER_W-1:0];
  assign e_w   = (neg_i && (r_w != '0)) ? per_i - r_w : r_w;
  assign h_tri = ({e_w, 1'b0} < {1'b0, per_i}) ? e_w : per_i - e_w;
  assign h_w   = saw ? e_w : h_tri;
  assign n1_w  = saw ? {1'b0, e_w} : {h_tri, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_h_q    <= h_w;
      a_n1_q   <= n1_w;
      b_prod_q <= bw_w * a_n1_q;
      b_hh_q   <= a_h_q * a_h_q;
      b_bh_q   <= FREQ_W'(base_w * a_h_q);
      c_prod_q <= b_prod_q;
      c_bh_q   <= b_bh_q;
      c_plo_q  <= bw_w * b_hh_q[PER_W-1:0];
      c_phi_q  <= bw_w * b_hh_q[HH_W-1:PER_W];
      d_off_q  <= NUM_W'(c_prod_q);
      d_quad_q <= NUM_W'(c_plo_q) + {c_phi_q, {PER_W{1'b0}}};
      d_bh_q   <= c_bh_q;
    end
  end

  assign vld_o      = vld_q[3];
  assign off_num_o  = d_off_q;
  assign quad_num_o = d_quad_q;
  assign bh_o       = d_bh_q;

endmodule

/* hdl/fmcw_chirp_freq_phase.sv */
// channel  | dir | handshake              | content
// s_axis   | in  | tvalid/tready          | tdata: time_ticks
// m_axis   | out | tvalid/tready          | tdata: inst_freq, phase_cycles; tuser: result_valid
// cfg      | in  | cfg_we_i               | cfg_idx_i selects mode, base, sweep, period
// one item per clock sustained while the skid register is empty; the path runs through the
// input register, a bit-per-stage divider (time modulo period), the fold, three multiply
// stages, two parallel bit-per-stage dividers (frequency and phase quotients) and the output register
// a skid register behind the output takes one item when m_axis stalls; while it is full
// the whole pipeline holds and s_axis_tready is low
// reset clears valid bits and the skid full flag and loads default configuration only
module fmcw_chirp_freq_phase
  import fcp_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // time_ticks
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((2*FREQ_WIDTH+8)/8)*8-1:0] m_axis_tdata,  // inst_freq, phase_cycles
  output logic                              m_axis_tuser   // result_valid
);

  `include "fmcw_chirp_freq_phase_defines.svh"

  localparam int OUT_W = ((2 * FREQ_WIDTH + 8) / 8) * 8;
  localparam int NUM_W = FREQ_WIDTH + 2 * PER_W;
  localparam int RES_W = 2 * FREQ_WIDTH + 1;

  chirp_cfg_t cfg_q;
  logic       en;

  logic [TIME_WIDTH-1:0] t_w;
  logic                  in_vld_q, in_neg_q;
  logic [TIME_WIDTH-1:0] in_mag_q;

  logic [PER_W-1:0] per_w;
  logic             saw;
  logic             mode_ok;

  logic              d1_vld, d1_neg;
  logic [DIV_W-1:0]  d1_rem;
  logic              fm_vld;
  logic [NUM_W-1:0]  fm_off, fm_quad;
  logic [FREQ_WIDTH-1:0] fm_bh;

  logic                  da_vld;
  logic [FREQ_WIDTH:0]   da_quo, db_quo;
  logic [FREQ_WIDTH-1:0] da_bh;

  logic                  out_vld_q, out_ok_q;
  logic [FREQ_WIDTH:0]   out_inst_q;
  logic [FREQ_WIDTH-1:0] out_phase_q;
  logic                  skid_full_q, skid_ok_q;
  logic [FREQ_WIDTH:0]   skid_inst_q;
  logic [FREQ_WIDTH-1:0] skid_phase_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_OFF;
      cfg_q.base   <= '0;
      cfg_q.bw     <= '0;
      cfg_q.period <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:   cfg_q.mode   <= cfg_data_i[1:0];
        REG_BASE:   cfg_q.base   <= cfg_data_i;
        REG_BW:     cfg_q.bw     <= cfg_data_i;
        REG_PERIOD: cfg_q.period <= cfg_data_i;
        default:    cfg_q.mode   <= cfg_q.mode;
      endcase
    end
  end

  assign per_w   = (cfg_q.period == '0) ? PER_W'(1) : PER_W'(cfg_q.period);
  assign saw     = cfg_q.mode == MODE_SAW;
  assign mode_ok = (cfg_q.mode == MODE_TRI) || (cfg_q.mode == MODE_SAW);

  assign en            = !skid_full_q;
  assign s_axis_tready = en;

  // input stage: sign and magnitude
  assign t_w = s_axis_tdata[TIME_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_neg_q <= t_w[TIME_WIDTH-1];
      in_mag_q <= t_w[TIME_WIDTH-1] ? ~t_w + 1'b1 : t_w;
    end
  end

  fcp_div_pipe #(
    .NUM_W  (TIME_WIDTH),
    .QUO_W  (2),
    .SIDE_W (1)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_vld_q),
    .num_i  (in_mag_q),
    .den_i  ({1'b0, per_w}),
    .side_i (in_neg_q),
    .vld_o  (d1_vld),
    .quo_o  (),
    .rem_o  (d1_rem),
    .side_o (d1_neg)
  );

  fcp_fold_mul #(
    .FREQ_W (FREQ_WIDTH)
  ) u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .per_i      (per_w),
    .vld_i      (d1_vld),
    .rem_i      (d1_rem),
    .neg_i      (d1_neg),
    .vld_o      (fm_vld),
    .off_num_o  (fm_off),
    .quad_num_o (fm_quad),
    .bh_o       (fm_bh)
  );

  // frequency offset quotient, carries base*h alongside
  fcp_div_pipe #(
    .NUM_W  (NUM_W),
    .QUO_W  (FREQ_WIDTH + 1),
    .SIDE_W (FREQ_WIDTH)
  ) u_div_off (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fm_vld),
    .num_i  (fm_off),
    .den_i  ({1'b0, per_w}),
    .side_i (fm_bh),
    .vld_o  (da_vld),
    .quo_o  (da_quo),
    .rem_o  (),
    .side_o (da_bh)
  );

  // phase quadratic term, divisor doubles in sawtooth mode
  fcp_div_pipe #(
    .NUM_W  (NUM_W),
    .QUO_W  (FREQ_WIDTH + 1),
    .SIDE_W (1)
  ) u_div_quad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fm_vld),
    .num_i  (fm_quad),
    .den_i  (saw ? {per_w, 1'b0} : {1'b0, per_w}),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (db_quo),
    .rem_o  (),
    .side_o ()
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= da_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ok_q    <= mode_ok;
      out_inst_q  <= mode_ok ? (FREQ_WIDTH + 1)'(FREQ_WIDTH'(cfg_q.base)) + da_quo : '0;
      out_phase_q <= mode_ok ? da_bh + db_quo[FREQ_WIDTH-1:0] : '0;
    end
  end

  // skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      skid_full_q <= !m_axis_tready;
    end else begin
      skid_full_q <= out_vld_q && !m_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_ok_q    <= out_ok_q;
      skid_inst_q  <= out_inst_q;
      skid_phase_q <= out_phase_q;
    end
  end

  assign m_axis_tvalid = skid_full_q || out_vld_q;
  assign m_axis_tuser  = skid_full_q ? skid_ok_q : out_ok_q;
  assign m_axis_tdata  = skid_full_q ? OUT_W'({skid_phase_q, skid_inst_q})
                                     : OUT_W'({out_phase_q, out_inst_q});

  `FCP_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `FCP_ASSERT_NOW(a_skid_from_out, $rose(skid_full_q), $past(out_vld_q))
  `FCP_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[RES_W-1:0] == '0)

endmodule

/* tb/sv/tb.sv */
module tb
  import fcp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 48;
  localparam int FW = 32;
  localparam int LATENCY = TW + FW + 70;

  typedef struct {
    logic [FW:0]   freq;
    logic [FW-1:0] phase;
    logic          ok;
  } chirp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [1:0]  mode_q = MODE_OFF;
  logic [31:0] base_q = '0;
  logic [31:0] bw_q = '0;
  logic [31:0] period_q = 32'd1;

  chirp_res_t expected_q[$];
  int  errors = 0;
  bit  hold_off = 1'b0;
  int  stall_max = 3;

  always #10 clk_i = ~clk_i;

  fmcw_chirp_freq_phase u_top (.*);

  function automatic chirp_res_t predict_chirp(logic [TW-1:0] t);
    chirp_res_t r;
    logic [63:0] p, e, h, mag, rem;
    logic [127:0] off, quad;
    p = (period_q == 0) ? 64'd1 : {32'd0, period_q};
    r.freq = '0;
    r.phase = '0;
    r.ok = 1'b0;
    if (mode_q == MODE_TRI || mode_q == MODE_SAW) begin
      if (t[TW-1]) begin
        mag = {16'd0, -t};
        rem = mag % p;
        e = (rem == 0) ? 64'd0 : p - rem;
      end else begin
        e = {16'd0, t} % p;
      end
      if (mode_q == MODE_SAW) begin
        h = e;
        off = (128'(bw_q) * 128'(e)) / 128'(p);
        quad = (128'(bw_q) * 128'(h * h)) / (128'(p) * 2);
      end else begin
        h = (2 * e < p) ? e : p - e;
        off = (128'(bw_q) * 128'(2 * h)) / 128'(p);
        quad = (128'(bw_q) * 128'(h * h)) / 128'(p);
      end
      r.freq = 33'(base_q) + off[32:0];
      r.phase = 32'(64'(base_q) * h) + quad[31:0];
      r.ok = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:   mode_q = val[1:0];
      REG_BASE:   base_q = val;
      REG_BW:     bw_q = val;
      default:    period_q = val;
    endcase
  endtask

  task automatic set_chirp(logic [1:0] m, logic [31:0] b, logic [31:0] w, logic [31:0] p);
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_BASE, b);
    write_reg(REG_BW, w);
    write_reg(REG_PERIOD, p);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // sender side, inputs change on the falling edge; valid stays up between items unless a gap is inserted
  task automatic send_time(logic [TW-1:0] t, bit gaps);
    int g;
    g = 0;
    if (gaps) begin
      g = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
    end
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.insert(expected_q.size(), predict_chirp(t));
    @(negedge clk_i);
  endtask

  function automatic logic [TW-1:0] rand_time();
    logic [TW-1:0] t;
    t = TW'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: t = TW'($signed(32'($urandom_range(0, 4000))) - 2000);
      1: t = TW'($signed({1'b0, $urandom}) * ($urandom_range(0, 1) ? 1 : -1));
      default: ;
    endcase
    return t;
  endfunction

  // receiver side with random stalls and an optional long hold
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 4) == 0)
      m_axis_tready <= ($urandom_range(0, stall_max) == 0);
    else
      m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    chirp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[32:0] !== want.freq) begin
          $error("inst_freq expected %h got %h", want.freq, m_axis_tdata[32:0]);
          errors++;
        end
        if (m_axis_tdata[64:33] !== want.phase) begin
          $error("phase_cycles expected %h got %h", want.phase, m_axis_tdata[64:33]);
          errors++;
        end
        if (m_axis_tuser !== want.ok) begin
          $error("result_valid expected %b got %b", want.ok, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_state;
    send_time(48'd5, 0);
    send_time(48'hFFFF_FFFF_FFFF, 0);
    drain();
  endtask

  task automatic test_directed;
    logic [TW-1:0] times[8];
    times = '{48'd0, 48'd1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
              48'hFFFF_FFFF_FFFF, 48'd999, -48'sd1000, 48'd500};
    for (int m = 0; m < 4; m++) begin
      set_chirp(m[1:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, (m == 1) ? 32'hFFFF_FFFF : 32'd1000);
      foreach (times[i]) send_time(times[i], 0);
      drain();
    end
    // zero period acts as period one, so the folded time is zero
    set_chirp(MODE_TRI, 32'd7, 32'd99, 32'd0);
    send_time(48'd12345, 0);
    send_time(-48'sd3, 0);
    drain();
    set_chirp(MODE_SAW, 32'd0, 32'd0, 32'd1);
    send_time(48'h5555_AAAA_5555, 0);
    drain();
  endtask

  task automatic test_random;
    logic [31:0] per;
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 2))
        0: per = $urandom_range(1, 64);
        1: per = $urandom_range(1, 100000);
        default: per = $urandom;
      endcase
      set_chirp((ph % 5 == 4) ? 2'($urandom_range(2, 3)) : 2'(ph % 2), $urandom, $urandom, per);
      stall_max = (ph % 3 == 0) ? 0 : 3;
      for (int i = 0; i < 220; i++) send_time(rand_time(), ph != 3);
      drain();
    end
  endtask

  task automatic test_backpressure;
    set_chirp(MODE_SAW, $urandom, $urandom, 32'd777);
    fork
      begin
        hold_off = 1'b1;
        repeat (LATENCY * 2) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < LATENCY + 20; i++) send_time(rand_time(), 0);
    join
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed();
    test_random();
    test_backpressure();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
